// ===== rtl/core/dap_pkg.sv =====
// ----------------------------------------------------------------------------
// dap_pkg
// Shared types and constants of the warping path block: field widths,
// register indexes, parameter defaults and the queued cell beat.
// ----------------------------------------------------------------------------
package dap_pkg;

   // parameter defaults
   localparam int MAX_ROWS_DEF  = 32;
   localparam int MAX_COLS_DEF  = 32;
   localparam int COST_BITS_DEF = 24;

   // fixed field widths
   localparam int COST_IN_W  = 16;
   localparam int IDX_W      = 5;
   localparam int SIZE_W     = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;
   localparam int RING_SEL_W = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_PATTERN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_USED    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_USED    = 2'd2;

   // register reset values
   localparam logic              PATTERN_RESET = 1'b1;
   localparam logic [SIZE_W-1:0] ROWS_RESET    = 6'd32;
   localparam logic [SIZE_W-1:0] COLS_RESET    = 6'd32;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // one classified cost beat
   typedef struct packed {
      logic [COST_IN_W-1:0]  cost;
      logic [IDX_W-1:0]      row;
      logic [IDX_W-1:0]      col;
      logic [RING_SEL_W-1:0] ring;
      logic                  pattern;
      logic                  last;
   } cell_type;

endpackage

// ===== rtl/core/dap_req_if.sv =====
// ----------------------------------------------------------------------------
// dap_req_if
// Cost input channel: one local cost per beat.
// ----------------------------------------------------------------------------
interface dap_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] local_cost;

   modport source (output valid, output local_cost, input ready);
   modport sink   (input valid, input local_cost, output ready);
endinterface

// ===== rtl/core/dap_rsp_if.sv =====
// ----------------------------------------------------------------------------
// dap_rsp_if
// Path output channel: one warping path point per beat.
// ----------------------------------------------------------------------------
interface dap_rsp_if;
   logic       valid;
   logic       ready;
   logic [4:0] row_index;
   logic [4:0] col_index;
   logic       path_end;

   modport source (output valid, output row_index, output col_index, output path_end,
                   input ready);
   modport sink   (input valid, input row_index, input col_index, input path_end,
                   output ready);
endinterface

// ===== rtl/core/dap_csr_if.sv =====
// ----------------------------------------------------------------------------
// dap_csr_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface dap_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [5:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/dap_queue.sv =====
// ----------------------------------------------------------------------------
// dap_queue
// Small fifo of classified cost beats between the front and the back.
// ----------------------------------------------------------------------------
module dap_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dap_pkg::cell_type push_data,
   output logic              full,
   input  logic              pop,
   output dap_pkg::cell_type head_data,
   output logic              head_valid
);
   import dap_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cell_type         slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/dap_front.sv =====
// ----------------------------------------------------------------------------
// dap_front
// Holds the configuration registers, tracks the load position and tags
// each accepted cost beat with its cell, ring row and last-cell flag.
// ----------------------------------------------------------------------------
module dap_front #(
   parameter int MAX_ROWS = dap_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = dap_pkg::MAX_COLS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   dap_req_if.sink           req_chan,
   dap_csr_if.sink           csr_chan,
   input  logic              queue_full,
   output logic              push,
   output dap_pkg::cell_type push_data
);
   import dap_pkg::*;

   logic              pattern_ff, pattern_in;
   logic [SIZE_W-1:0] rows_ff, rows_in;
   logic [SIZE_W-1:0] cols_ff, cols_in;
   logic [IDX_W-1:0]  load_row_ff, load_row_in;
   logic [IDX_W-1:0]  load_col_ff, load_col_in;
   logic [1:0]        ring_ff, ring_in;
   logic [SIZE_W-1:0] rows_eff, cols_eff;
   logic [IDX_W-1:0]  last_row, last_col, cur_row, cur_col;
   logic [1:0]        cur_ring;
   logic              csr_beat, restart, out_of_range;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = !queue_full;
   assign csr_beat       = csr_chan.valid;
   assign push           = req_chan.valid && !queue_full;

   // clamp the matrix size into 1..max
   always_comb begin
      rows_eff = rows_ff;
      cols_eff = cols_ff;
      if (rows_ff == '0) begin
         rows_eff = SIZE_W'(1);
      end else if (rows_ff > SIZE_W'(MAX_ROWS)) begin
         rows_eff = SIZE_W'(MAX_ROWS);
      end
      if (cols_ff == '0) begin
         cols_eff = SIZE_W'(1);
      end else if (cols_ff > SIZE_W'(MAX_COLS)) begin
         cols_eff = SIZE_W'(MAX_COLS);
      end
   end

   assign last_row     = IDX_W'(rows_eff - SIZE_W'(1));
   assign last_col     = IDX_W'(cols_eff - SIZE_W'(1));
   assign out_of_range = (load_row_ff > last_row) || (load_col_ff > last_col);
   assign cur_row      = out_of_range ? '0 : load_row_ff;
   assign cur_col      = out_of_range ? '0 : load_col_ff;
   assign cur_ring     = out_of_range ? 2'd1 : ring_ff;

   // classified beat
   always_comb begin
      push_data.cost    = req_chan.local_cost;
      push_data.row     = cur_row;
      push_data.col     = cur_col;
      push_data.ring    = cur_ring;
      push_data.pattern = pattern_ff;
      push_data.last    = (cur_row == last_row) && (cur_col == last_col);
   end

   // register writes and load position
   always_comb begin
      pattern_in  = pattern_ff;
      rows_in     = rows_ff;
      cols_in     = cols_ff;
      load_row_in = load_row_ff;
      load_col_in = load_col_ff;
      ring_in     = ring_ff;
      restart     = 1'b0;
      if (csr_beat) begin
         unique case (csr_chan.index)
            CSR_STEP_PATTERN: begin
               pattern_in = csr_chan.data[0];
               restart    = 1'b1;
            end
            CSR_ROWS_USED: begin
               rows_in = csr_chan.data;
               restart = 1'b1;
            end
            CSR_COLS_USED: begin
               cols_in = csr_chan.data;
               restart = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
      if (restart) begin
         load_row_in = '0;
         load_col_in = '0;
         ring_in     = 2'd1;
      end else if (push) begin
         if (cur_col != last_col) begin
            load_row_in = cur_row;
            load_col_in = cur_col + IDX_W'(1);
            ring_in     = cur_ring;
         end else if (cur_row != last_row) begin
            load_row_in = cur_row + IDX_W'(1);
            load_col_in = '0;
            ring_in     = (cur_ring == 2'd2) ? 2'd0 : cur_ring + 2'd1;
         end else begin
            load_row_in = '0;
            load_col_in = '0;
            ring_in     = 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff  <= PATTERN_RESET;
         rows_ff     <= ROWS_RESET;
         cols_ff     <= COLS_RESET;
         load_row_ff <= '0;
         load_col_ff <= '0;
         ring_ff     <= 2'd1;
      end else begin
         pattern_ff  <= pattern_in;
         rows_ff     <= rows_in;
         cols_ff     <= cols_in;
         load_row_ff <= load_row_in;
         load_col_ff <= load_col_in;
         ring_ff     <= ring_in;
      end
   end

endmodule

// ===== rtl/core/dap_back.sv =====
// ----------------------------------------------------------------------------
// dap_back
// Accumulated-cost cell update over a three-row ring store, step choice
// store, traceback walk and front-to-back path output.
// ----------------------------------------------------------------------------
module dap_back #(
   parameter int MAX_ROWS  = dap_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS  = dap_pkg::MAX_COLS_DEF,
   parameter int COST_BITS = dap_pkg::COST_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  dap_pkg::cell_type head_data,
   input  logic              head_valid,
   output logic              head_pop,
   dap_rsp_if.source         rsp_chan
);
   import dap_pkg::*;

   localparam int RING_W     = MAX_COLS + 1;
   localparam int CA_DEPTH   = 3 * RING_W;
   localparam int CA_W       = $clog2(CA_DEPTH);
   localparam int CH_DEPTH   = MAX_ROWS * MAX_COLS;
   localparam int CH_W       = $clog2(CH_DEPTH);
   localparam int PATH_DEPTH = MAX_ROWS + MAX_COLS - 1;
   localparam int PB_W       = $clog2(PATH_DEPTH);
   localparam int CNT_W      = $clog2(PATH_DEPTH + 1);
   localparam int SUM_W      = COST_BITS + 2;
   localparam int PT_W       = 2 * IDX_W;
   localparam logic [COST_BITS-1:0] INF = '1;

   // step codes
   localparam logic [2:0] CODE_DIAG  = 3'd1;
   localparam logic [2:0] CODE_TWO   = 3'd2;
   localparam logic [2:0] CODE_THREE = 3'd3;
   localparam logic [2:0] CODE_FOUR  = 3'd4;
   localparam logic [2:0] CODE_FIVE  = 3'd5;

   // states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SUM   = 3'd1;
   localparam logic [2:0] S_MIN   = 3'd2;
   localparam logic [2:0] S_WR    = 3'd3;
   localparam logic [2:0] S_TBRD  = 3'd4;
   localparam logic [2:0] S_TBMV  = 3'd5;
   localparam logic [2:0] S_EMRD  = 3'd6;
   localparam logic [2:0] S_EMOUT = 3'd7;

   function automatic logic [COST_BITS-1:0] sat_add(input logic [COST_BITS-1:0] a,
                                                    input logic [SUM_W-1:0]     b);
      logic [SUM_W-1:0] s;
      s = SUM_W'(a) + b;
      if (s > SUM_W'(INF)) begin
         sat_add = INF;
      end else begin
         sat_add = s[COST_BITS-1:0];
      end
   endfunction

   logic [2:0]           state_ff, state_in;
   cell_type             cur_ff, cur_in;
   logic [COST_BITS-1:0] cand_ff [5];
   logic [COST_BITS-1:0] cand_in [5];
   logic [4:0]           en_ff, en_in;
   logic [COST_BITS-1:0] up_ff, up_in, diag_ff, diag_in;
   logic [COST_BITS-1:0] min_ff, min_in;
   logic [2:0]           code_ff, code_in;
   logic [COST_BITS-1:0] prev_up_ff, prev_up_in, prev_diag_ff, prev_diag_in;
   logic [COST_BITS-1:0] left_ff, left_in;
   logic [IDX_W-1:0]     tb_row_ff, tb_row_in, tb_col_ff, tb_col_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in, k_ff, k_in;

   logic [COST_BITS-1:0] cost_mem [CA_DEPTH];
   logic [COST_BITS-1:0] rd_a_ff, rd_b_ff;
   logic [2:0]           choice_mem [CH_DEPTH];
   logic [2:0]           choice_rd_ff;
   logic [PT_W-1:0]      path_mem [PATH_DEPTH];
   logic [PT_W-1:0]      path_rd_ff;

   logic [1:0]           ring_prev, ring_prev2;
   logic [CA_W-1:0]      rd_a_addr, rd_b_addr, cost_wr_addr;
   logic                 cost_we, choice_we, path_we;
   logic [COST_BITS-1:0] cost_wr_data;
   logic [CH_W-1:0]      choice_wr_addr, choice_rd_addr;
   logic [PB_W-1:0]      path_wr_addr, path_rd_addr;
   logic [PT_W-1:0]      path_wr_data;
   logic [CNT_W-1:0]     emit_pos;

   logic [SUM_W-1:0]     d_one, d_two;
   logic [COST_BITS-1:0] col0_val, r_diag, r_up, r_left, r_left2, r_up2;
   logic [COST_BITS-1:0] run_min, final_cost;
   logic [2:0]           run_code;
   logic [1:0]           dr, dc;
   logic                 tb_go;

   // ring row addresses for the rows above
   assign ring_prev  = (head_data.ring == 2'd0) ? 2'd2 : head_data.ring - 2'd1;
   assign ring_prev2 = (head_data.ring == 2'd2) ? 2'd0 : head_data.ring + 2'd1;
   assign rd_a_addr  = CA_W'(ring_prev) * CA_W'(RING_W) + CA_W'(head_data.col) + CA_W'(1);
   assign rd_b_addr  = CA_W'(ring_prev2) * CA_W'(RING_W) + CA_W'(head_data.col);
   assign cost_wr_addr = CA_W'(cur_ff.ring) * CA_W'(RING_W) + CA_W'(cur_ff.col) + CA_W'(1);

   // neighbor values with the border resolved
   assign d_one    = SUM_W'(cur_ff.cost);
   assign d_two    = d_one << 1;
   assign col0_val = (cur_ff.row == '0) ? '0 : INF;
   assign r_diag   = (cur_ff.col == '0) ? col0_val : prev_up_ff;
   assign r_left2  = (cur_ff.col == '0) ? col0_val : prev_diag_ff;
   assign r_up     = (cur_ff.row == '0) ? INF : rd_a_ff;
   assign r_left   = (cur_ff.col == '0) ? INF : left_ff;
   assign r_up2    = (cur_ff.row <= IDX_W'(1)) ? ((cur_ff.col == '0) ? '0 : INF)
                   : ((cur_ff.col == '0) ? INF : rd_b_ff);

   // running minimum, lowest code wins ties
   always_comb begin
      run_min  = cand_ff[0];
      run_code = CODE_DIAG;
      for (int k = 1; k < 5; k++) begin
         if (en_ff[k] && (cand_ff[k] < run_min)) begin
            run_min  = cand_ff[k];
            run_code = 3'(k + 1);
         end
      end
   end

   assign final_cost = cur_ff.pattern ? min_ff : sat_add(min_ff, d_one);

   // traceback move for the stored code
   always_comb begin
      dr = 2'd1;
      dc = 2'd1;
      if (!cur_ff.pattern) begin
         if (choice_rd_ff == CODE_TWO) begin
            dc = 2'd0;
         end else if (choice_rd_ff == CODE_THREE) begin
            dr = 2'd0;
         end
      end else begin
         if (choice_rd_ff == CODE_TWO) begin
            dr = 2'd2;
         end else if (choice_rd_ff == CODE_THREE) begin
            dc = 2'd2;
         end else if (choice_rd_ff == CODE_FOUR) begin
            dc = 2'd0;
         end else if (choice_rd_ff == CODE_FIVE) begin
            dr = 2'd0;
         end
      end
   end

   assign tb_go          = (tb_row_ff != '0) && (tb_col_ff != '0)
                        && (cnt_ff < CNT_W'(PATH_DEPTH));
   assign choice_wr_addr = CH_W'(cur_ff.row) * CH_W'(MAX_COLS) + CH_W'(cur_ff.col);
   assign choice_rd_addr = CH_W'(tb_row_ff) * CH_W'(MAX_COLS) + CH_W'(tb_col_ff);
   assign emit_pos       = cnt_ff - CNT_W'(1) - k_ff;
   assign path_rd_addr   = emit_pos[PB_W-1:0];

   // control and datapath next state
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      for (int k = 0; k < 5; k++) begin
         cand_in[k] = cand_ff[k];
      end
      en_in        = en_ff;
      up_in        = up_ff;
      diag_in      = diag_ff;
      min_in       = min_ff;
      code_in      = code_ff;
      prev_up_in   = prev_up_ff;
      prev_diag_in = prev_diag_ff;
      left_in      = left_ff;
      tb_row_in    = tb_row_ff;
      tb_col_in    = tb_col_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      head_pop     = 1'b0;
      cost_we      = 1'b0;
      choice_we    = 1'b0;
      path_we      = 1'b0;
      path_wr_addr = cnt_ff[PB_W-1:0];
      path_wr_data = {tb_row_ff, tb_col_ff};
      unique case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               head_pop = 1'b1;
               cur_in   = head_data;
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            up_in   = r_up;
            diag_in = r_diag;
            if (cur_ff.pattern) begin
               cand_in[0] = sat_add(r_diag, d_one);
               cand_in[1] = sat_add(r_up2, d_two);
               cand_in[2] = sat_add(r_left2, d_two);
               cand_in[3] = sat_add(r_up, d_one);
               cand_in[4] = sat_add(r_left, d_one);
               en_in      = 5'b11111;
            end else begin
               cand_in[0] = r_diag;
               cand_in[1] = r_up;
               cand_in[2] = r_left;
               en_in      = 5'b00111;
            end
            state_in = S_MIN;
         end
         S_MIN: begin
            min_in   = run_min;
            code_in  = run_code;
            state_in = S_WR;
         end
         S_WR: begin
            cost_we      = 1'b1;
            choice_we    = 1'b1;
            prev_up_in   = up_ff;
            prev_diag_in = diag_ff;
            left_in      = final_cost;
            if (cur_ff.last) begin
               path_we      = 1'b1;
               path_wr_addr = '0;
               path_wr_data = {cur_ff.row, cur_ff.col};
               tb_row_in    = cur_ff.row;
               tb_col_in    = cur_ff.col;
               cnt_in       = CNT_W'(1);
               state_in     = S_TBRD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_TBRD: begin
            if (tb_go) begin
               state_in = S_TBMV;
            end else begin
               k_in     = '0;
               state_in = S_EMRD;
            end
         end
         S_TBMV: begin
            tb_row_in    = (tb_row_ff >= IDX_W'(dr)) ? tb_row_ff - IDX_W'(dr) : '0;
            tb_col_in    = (tb_col_ff >= IDX_W'(dc)) ? tb_col_ff - IDX_W'(dc) : '0;
            path_we      = 1'b1;
            path_wr_data = {tb_row_in, tb_col_in};
            cnt_in       = cnt_ff + CNT_W'(1);
            state_in     = S_TBRD;
         end
         S_EMRD: begin
            state_in = S_EMOUT;
         end
         S_EMOUT: begin
            if (rsp_chan.ready) begin
               if (rsp_chan.path_end) begin
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + CNT_W'(1);
                  state_in = S_EMRD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      for (int k = 0; k < 5; k++) begin
         cand_ff[k] <= cand_in[k];
      end
      en_ff        <= en_in;
      up_ff        <= up_in;
      diag_ff      <= diag_in;
      min_ff       <= min_in;
      code_ff      <= code_in;
      prev_up_ff   <= prev_up_in;
      prev_diag_ff <= prev_diag_in;
      left_ff      <= left_in;
      tb_row_ff    <= tb_row_in;
      tb_col_ff    <= tb_col_in;
      cnt_ff       <= cnt_in;
      k_ff         <= k_in;
   end

   assign cost_wr_data = final_cost;

   // ring row store, two read ports
   always_ff @(posedge clock) begin
      if (cost_we) begin
         cost_mem[cost_wr_addr] <= cost_wr_data;
      end
      rd_a_ff <= cost_mem[rd_a_addr];
      rd_b_ff <= cost_mem[rd_b_addr];
   end

   // step choice store
   always_ff @(posedge clock) begin
      if (choice_we) begin
         choice_mem[choice_wr_addr] <= code_ff;
      end
      choice_rd_ff <= choice_mem[choice_rd_addr];
   end

   // path point store
   always_ff @(posedge clock) begin
      if (path_we) begin
         path_mem[path_wr_addr] <= path_wr_data;
      end
      path_rd_ff <= path_mem[path_rd_addr];
   end

   // output beat
   assign rsp_chan.valid     = (state_ff == S_EMOUT);
   assign rsp_chan.row_index = path_rd_ff[PT_W-1:IDX_W];
   assign rsp_chan.col_index = path_rd_ff[IDX_W-1:0];
   assign rsp_chan.path_end  = (k_ff == cnt_ff - CNT_W'(1));

endmodule

// ===== rtl/core/dtw_alignment_path.sv =====
// ----------------------------------------------------------------------------
// dtw_alignment_path
// Dynamic time warping with traceback: accumulated cost over a matrix of
// local costs and the warping path from the top-left to the bottom-right.
// ----------------------------------------------------------------------------
// Usage:
//   csr_chan writes step_pattern (index 0), rows_used (1), cols_used (2);
//   a write to one of these restarts loading at the top-left cell. Write only when idle.
//   req_chan takes one 16-bit local cost per beat in row-major order.
//   rsp_chan gives the path points front to back after the last cost,
//   path_end set on the bottom-right point; other costs give no beat.
// Flow:
//   a cost beat enters a 4-entry queue; the cell unit takes one cell at a
//   time through ring store read, candidate sums, minimum, write back.
//   After the last cell the traceback walks each path point through a
//   step store read and a move, then each output beat goes through a
//   path store read and the beat itself, held by any receiver stall.
// Reset clears the control state and the registers to their defaults.
// A stalled receiver holds the output beat; costs keep filling the queue
// and req ready drops only when it is full.
module dtw_alignment_path #(
   parameter int MAX_ROWS  = dap_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS  = dap_pkg::MAX_COLS_DEF,
   parameter int COST_BITS = dap_pkg::COST_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   dap_req_if.sink   req_chan,
   dap_rsp_if.source rsp_chan,
   dap_csr_if.sink   csr_chan
);
   import dap_pkg::*;

   logic     push, queue_full, head_valid, head_pop;
   cell_type push_data, head_data;

   // front: registers and classification
   dap_front #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_chan   (csr_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   // queue between the two sides
   dap_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (head_pop),
      .head_data  (head_data),
      .head_valid (head_valid)
   );

   // back: cell update, traceback and output
   dap_back #(
      .MAX_ROWS  (MAX_ROWS),
      .MAX_COLS  (MAX_COLS),
      .COST_BITS (COST_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_data  (head_data),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ===== rtl/core/dap_checker.sv =====
// ----------------------------------------------------------------------------
// dap_checker
// Port-level checks on the path output channel, bound to the top level.
// ----------------------------------------------------------------------------
module dap_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [4:0] rsp_row_index,
   input logic [4:0] rsp_col_index,
   input logic       rsp_path_end
);

   // stalled beat stays
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   // stalled beat holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable({rsp_row_index, rsp_col_index, rsp_path_end}))
      else $error("rsp payload changed while stalled");

   // each point needs a store read before it shows
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("rsp beat followed without path read");

   // a path continues until its end point
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_path_end |=> ##1 rsp_valid)
      else $error("path stopped before its end point");

   // nothing shows right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp beat right after reset");

endmodule

bind dtw_alignment_path dap_checker u_dap_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_row_index (rsp_chan.row_index),
   .rsp_col_index (rsp_chan.col_index),
   .rsp_path_end  (rsp_chan.path_end)
);

// ===== verif/dtw_alignment_path_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtw_alignment_path_tb
// Streams cost matrices of many sizes under both step patterns into the
// warping path block. A local predictor builds the accumulated costs and
// the traceback, and every path point that comes out is compared field by
// field against it. Both handshake sides idle at random, and the receiver
// holds off once for a long stretch.
// ----------------------------------------------------------------------------
module dtw_alignment_path_tb;
   import dap_pkg::*;

   localparam int NROWS = MAX_ROWS_DEF;
   localparam int NCOLS = MAX_COLS_DEF;
   localparam int CBITS = COST_BITS_DEF;
   localparam logic [CBITS-1:0] INF_COST = {CBITS{1'b1}};
   localparam int PATH_MAX = NROWS + NCOLS - 1;

   // step codes
   localparam logic [2:0] STEP_DIAG   = 3'd1;
   localparam logic [2:0] STEP_TWO    = 3'd2;
   localparam logic [2:0] STEP_THREE  = 3'd3;
   localparam logic [2:0] STEP_FOUR   = 3'd4;
   localparam logic [2:0] STEP_FIVE   = 3'd5;

   typedef struct packed {
      logic [IDX_W-1:0] row_index;
      logic [IDX_W-1:0] col_index;
      logic             path_end;
   } point_type;

   logic clock;
   logic reset;

   dap_req_if req_if ();
   dap_rsp_if rsp_if ();
   dap_csr_if csr_if ();

   dtw_alignment_path dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // predictor state
   logic              pat_q;
   logic [SIZE_W-1:0] rows_q;
   logic [SIZE_W-1:0] cols_q;
   logic [IDX_W-1:0]  ld_row;
   logic [IDX_W-1:0]  ld_col;
   logic [CBITS-1:0]  acc_cost [0:NROWS][0:NCOLS];
   logic [2:0]        best_step [0:NROWS-1][0:NCOLS-1];

   logic [COST_IN_W-1:0] cost_fifo [$];
   point_type            path_expect [$];
   int  errors;
   int  cycle_cnt;
   logic hold_arm;
   int   hold_cnt;

   function automatic int clamp_size(logic [SIZE_W-1:0] v, int hi);
      if (v < 1) return 1;
      return (v > hi) ? hi : int'(v);
   endfunction

   function automatic logic [CBITS-1:0] acc_read(int i, int j);
      if (i == 0 && j == 0) return '0;
      if (i == 0 || j == 0) return INF_COST;
      return acc_cost[i][j];
   endfunction

   function automatic logic [CBITS-1:0] sat_sum(logic [CBITS-1:0] a, logic [CBITS+1:0] b);
      logic [CBITS+1:0] s;
      s = (CBITS+2)'(a) + b;
      return (s > (CBITS+2)'(INF_COST)) ? INF_COST : s[CBITS-1:0];
   endfunction

   // one accepted cost: update the matrix, queue the path on the last cell
   task automatic predict_cell(logic [COST_IN_W-1:0] d);
      int nr, nc, r, c, i, j, n, dr, dc, k;
      logic [CBITS-1:0] best, cand;
      logic [CBITS+1:0] d1, d2;
      logic [2:0] code;
      logic [9:0] trail [PATH_MAX];
      point_type pt;
      d1 = (CBITS+2)'(d);
      d2 = d1 << 1;
      nr = clamp_size(rows_q, NROWS);
      nc = clamp_size(cols_q, NCOLS);
      if (ld_row >= nr || ld_col >= nc) begin
         ld_row = '0;
         ld_col = '0;
      end
      r = int'(ld_row);
      c = int'(ld_col);
      i = r + 1;
      j = c + 1;
      if (!pat_q) begin
         best = acc_read(i-1, j-1); code = STEP_DIAG;
         cand = acc_read(i-1, j);
         if (cand < best) begin best = cand; code = STEP_TWO; end
         cand = acc_read(i, j-1);
         if (cand < best) begin best = cand; code = STEP_THREE; end
         best = sat_sum(best, d1);
      end else begin
         best = sat_sum(acc_read(i-1, j-1), d1); code = STEP_DIAG;
         cand = sat_sum(acc_read((i >= 2) ? i-2 : 0, j-1), d2);
         if (cand < best) begin best = cand; code = STEP_TWO; end
         cand = sat_sum(acc_read(i-1, (j >= 2) ? j-2 : 0), d2);
         if (cand < best) begin best = cand; code = STEP_THREE; end
         cand = sat_sum(acc_read(i-1, j), d1);
         if (cand < best) begin best = cand; code = STEP_FOUR; end
         cand = sat_sum(acc_read(i, j-1), d1);
         if (cand < best) begin best = cand; code = STEP_FIVE; end
      end
      acc_cost[i][j] = best;
      best_step[r][c] = code;
      if (c + 1 < nc) begin
         ld_col = IDX_W'(c + 1);
         return;
      end
      ld_col = '0;
      if (r + 1 < nr) begin
         ld_row = IDX_W'(r + 1);
         return;
      end
      ld_row = '0;
      // traceback from the bottom-right cell
      r = nr - 1;
      c = nc - 1;
      n = 0;
      trail[n++] = {r[4:0], c[4:0]};
      while (r > 0 && c > 0 && n < PATH_MAX) begin
         dr = 1;
         dc = 1;
         code = best_step[r][c];
         if (!pat_q) begin
            if (code == STEP_TWO) dc = 0;
            else if (code == STEP_THREE) dr = 0;
         end else begin
            if (code == STEP_TWO) dr = 2;
            else if (code == STEP_THREE) dc = 2;
            else if (code == STEP_FOUR) dc = 0;
            else if (code == STEP_FIVE) dr = 0;
         end
         r = (r >= dr) ? r - dr : 0;
         c = (c >= dc) ? c - dc : 0;
         trail[n++] = {r[4:0], c[4:0]};
      end
      for (k = 0; k < n; k++) begin
         pt.row_index = trail[n-1-k][9:5];
         pt.col_index = trail[n-1-k][4:0];
         pt.path_end  = (k + 1 == n);
         path_expect.insert(path_expect.size(), pt);
      end
   endtask

   function automatic logic idle_now();
      if (cycle_cnt >= 1500 && cycle_cnt < 4000) return 1'b0;
      return $urandom_range(0, 99) < 21;
   endfunction

   // cost driver
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) predict_cell(req_if.local_cost);
         if (!req_if.valid || req_if.ready) begin
            if (cost_fifo.size() > 0 && !idle_now()) begin
               req_if.valid      <= 1'b1;
               req_if.local_cost <= cost_fifo.pop_front();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // path monitor
   always @(posedge clock) begin
      point_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (path_expect.size() == 0) begin
            $error("unexpected path beat row %0d col %0d", rsp_if.row_index, rsp_if.col_index);
            errors++;
         end else begin
            want = path_expect.pop_front();
            if (rsp_if.row_index !== want.row_index) begin
               $error("row_index expected %0d actual %0d", want.row_index, rsp_if.row_index);
               errors++;
            end
            if (rsp_if.col_index !== want.col_index) begin
               $error("col_index expected %0d actual %0d", want.col_index, rsp_if.col_index);
               errors++;
            end
            if (rsp_if.path_end !== want.path_end) begin
               $error("path_end expected %0d actual %0d", want.path_end, rsp_if.path_end);
               errors++;
            end
         end
      end
   end

   // receiver stalls, one long hold counted in cycles
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_if.ready <= 1'b0;
      end else if (hold_arm && rsp_if.valid) begin
         hold_arm <= 1'b0;
         hold_cnt <= 400;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= !idle_now();
      end
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      case (idx)
         CSR_STEP_PATTERN: pat_q  = val[0];
         CSR_ROWS_USED:    rows_q = val;
         CSR_COLS_USED:    cols_q = val;
         default: ;
      endcase
      ld_row = '0;
      ld_col = '0;
   endtask

   // wait until all costs are in and all points are out, then let cells drain
   task automatic wait_idle();
      while (cost_fifo.size() > 0 || req_if.valid || path_expect.size() > 0)
         @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic set_shape(logic pat, logic [SIZE_W-1:0] nr, logic [SIZE_W-1:0] nc);
      wait_idle();
      csr_write(CSR_STEP_PATTERN, {5'($urandom_range(0, 31)), pat});
      csr_write(CSR_ROWS_USED, nr);
      csr_write(CSR_COLS_USED, nc);
   endtask

   // append one cost to the pending queue
   task automatic add_cost(logic [COST_IN_W-1:0] v);
      cost_fifo.insert(cost_fifo.size(), v);
   endtask

   function automatic logic [COST_IN_W-1:0] rand_cost();
      case ($urandom_range(0, 9))
         0, 1, 2: return COST_IN_W'($urandom_range(0, 3));
         3:       return 16'hFFFF;
         default: return COST_IN_W'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic push_matrices(int count);
      int k, total;
      total = clamp_size(rows_q, NROWS) * clamp_size(cols_q, NCOLS) * count;
      for (k = 0; k < total; k++) add_cost(rand_cost());
   endtask

   // stimulus
   initial begin
      int sent;
      logic [SIZE_W-1:0] nr, nc;
      req_if.valid = 1'b0;
      req_if.local_cost = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data = '0;
      errors = 0;
      cycle_cnt = 0;
      hold_arm = 1'b0;
      hold_cnt = 0;
      pat_q = PATTERN_RESET;
      rows_q = ROWS_RESET;
      cols_q = COLS_RESET;
      ld_row = '0;
      ld_col = '0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: single cells at cost extremes, both patterns
      set_shape(1'b0, 6'd1, 6'd1);
      add_cost(16'h0000);
      add_cost(16'hFFFF);
      set_shape(1'b1, 6'd1, 6'd1);
      add_cost(16'hFFFF);
      // zero sizes clamp to one
      set_shape(1'b0, 6'd0, 6'd3);
      add_cost(16'd5); add_cost(16'd5); add_cost(16'd5);
      set_shape(1'b1, 6'd2, 6'd0);
      add_cost(16'd1); add_cost(16'd1);
      // flat 2x2 for ties, then a partly loaded matrix dropped by a write
      set_shape(1'b1, 6'd2, 6'd2);
      repeat (4) add_cost(16'd0);
      repeat (3) add_cost(16'd7);
      set_shape(1'b0, 6'd2, 6'd3);
      add_cost(16'd9); add_cost(16'd0); add_cost(16'd9);
      add_cost(16'd0); add_cost(16'd9); add_cost(16'd0);
      // oversize rows with one column gives the tallest matrix
      set_shape(1'b1, 6'd63, 6'd1);
      push_matrices(1);

      // back-to-back matrices while the receiver holds off
      set_shape(1'b1, 6'd3, 6'd3);
      hold_arm <= 1'b1;
      push_matrices(4);

      // widest matrix once
      set_shape(1'($urandom_range(0, 1)), 6'd8, 6'd32);
      push_matrices(1);

      // random shapes, mostly small
      sent = 0;
      while (sent < 135) begin
         if ($urandom_range(0, 9) == 0) begin
            nr = SIZE_W'($urandom_range(0, 63));
            nc = SIZE_W'($urandom_range(0, 63));
            if (nr * nc > 64) nc = SIZE_W'($urandom_range(1, 2));
         end else begin
            nr = SIZE_W'($urandom_range(1, 6));
            nc = SIZE_W'($urandom_range(1, 6));
         end
         set_shape(1'($urandom_range(0, 1)), nr, nc);
         push_matrices((nr * nc > 16) ? 1 : int'($urandom_range(1, 4)));
         sent += cost_fifo.size();
      end

      wait_idle();
      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
